// ===== sv/tdsac_pkg.sv =====
// ----------------------------------------------------------------------------
// tdsac_pkg
// Shared types and constants of the dissolved-solids averaging and
// calibration block: field widths, register indexes, datapath commands.
// ----------------------------------------------------------------------------
package tdsac_pkg;

    // Field and register widths
    localparam int GSUM_W      = 16;
    localparam int BSUM_W      = 16;
    localparam int CNT_W       = 4;
    localparam int COEF_CUB_W  = 16;
    localparam int COEF_SQ_W   = 16;
    localparam int COEF_LIN_W  = 18;
    localparam int VREF_W      = 13;
    localparam int MIN_PPM_W   = 12;
    localparam int PPM_W       = 16;
    localparam int MEAN_W      = 16;
    localparam int FAIL_W      = 4;
    localparam int M_TDATA_W   = 40;
    localparam int M_PAD_W     = M_TDATA_W - PPM_W - MEAN_W - FAIL_W;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 18;

    // Fixed-point scaling
    localparam int VOLT_FRAC   = 16;
    localparam int COEF_FRAC   = 8;
    localparam int PPM_FRAC    = 4;
    localparam int P_FRAC      = VOLT_FRAC + COEF_FRAC;
    localparam int P_SHIFT     = P_FRAC - PPM_FRAC;
    localparam int MV_PER_V    = 1000;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_CUBIC  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_SQUARE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_LINEAR = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_VREF_MV     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_PPM     = 3'd4;

    // Register reset values
    localparam logic [COEF_CUB_W-1:0] COEF_CUB_RST = 16'd17078;
    localparam logic [COEF_SQ_W-1:0]  COEF_SQ_RST  = 16'd32750;
    localparam logic [COEF_LIN_W-1:0] COEF_LIN_RST = 18'd109747;
    localparam logic [VREF_W-1:0]     VREF_RST     = 13'd3300;
    localparam logic [MIN_PPM_W-1:0]  MIN_PPM_RST  = 12'd20;

    // Operand pairs of the shared multiplier
    typedef enum logic [2:0] {
        MUL_SUM_VREF,
        MUL_V_V,
        MUL_V2_V,
        MUL_C3_V3,
        MUL_C1_V,
        MUL_C2_V2
    } mul_sel_t;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD,
        ACC_SUB
    } acc_op_t;

    typedef struct packed {
        logic     take;
        logic     end_group;
        logic     div_start;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     ld_v2;
        logic     ld_v3;
        logic     ld_v;
        acc_op_t  acc_op;
        logic     ld_ppm;
        logic     out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic group_full;
        logic batch_full;
        logic div_busy;
    } dp_status_t;

    function automatic int imax(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

endpackage

// ===== sv/tds_average_and_calibrate.sv =====
// ----------------------------------------------------------------------------
// tds_average_and_calibrate
// Two-level averaging of converter samples and cubic calibration to
// dissolved solids in 1/16 ppm.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: one beat per converter reading, sample in s_tdata, the
//   read-failure flag in s_tuser. Master stream: one beat per completed
//   batch of OUTER_GROUPS groups (ppm, batch mean code, failed groups).
//   Configuration registers are written through cfg_we / cfg_index /
//   cfg_data; the user writes them only while the block is idle, which
//   the block itself does not enforce. Throughput: beats are taken one
//   at a time. A beat that closes a group also takes a step that folds
//   the group mean into the batch sum. A beat that closes a batch then
//   runs the voltage division (two passes of a reciprocal product),
//   six passes through the single shared multiplier and the threshold
//   and saturation step, then loads the output register and raises m_tvalid.
//   The result sits in an output register; while the receiver stalls the
//   next batch keeps accumulating, and only a second finished result
//   waits for the first to be taken.
//   Reset clears all sums and counters, empties the output and loads the
//   default calibration coefficients.
// ----------------------------------------------------------------------------
module tds_average_and_calibrate
    import tdsac_pkg::*;
#(
    parameter int INNER_SAMPLES = 10,
    parameter int OUTER_GROUPS  = 10,
    parameter int SAMPLE_BITS   = 12,
    localparam int S_TDATA_W    = ((SAMPLE_BITS + 7) / 8) * 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // [SAMPLE_BITS-1:0] sample, rest zero
    input  logic                  s_tuser,   // [0] read_failed
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // [15:0] tds_ppm_sixteenths,
                                             // [31:16] mean_code_tenths,
                                             // [35:32] failed_groups, rest zero
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    dp_cmd_t          cmd;
    dp_status_t       status;
    logic [PPM_W-1:0]  tds_ppm_sixteenths;
    logic [MEAN_W-1:0] mean_code_tenths;
    logic [FAIL_W-1:0] failed_groups;

    tdsac_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    tdsac_datapath #(
        .INNER_SAMPLES (INNER_SAMPLES),
        .OUTER_GROUPS  (OUTER_GROUPS),
        .SAMPLE_BITS   (SAMPLE_BITS)
    ) u_datapath (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .status             (status),
        .sample             (s_tdata[SAMPLE_BITS-1:0]),
        .read_failed        (s_tuser),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .tds_ppm_sixteenths (tds_ppm_sixteenths),
        .mean_code_tenths   (mean_code_tenths),
        .failed_groups      (failed_groups)
    );

    assign m_tdata = {{M_PAD_W{1'b0}}, failed_groups, mean_code_tenths, tds_ppm_sixteenths};

endmodule

// ===== sv/tdsac_div.sv =====
// ----------------------------------------------------------------------------
// tdsac_div
// Division by a fixed constant as a reciprocal product, taken in two
// passes over the low and high halves of the reciprocal.
// ----------------------------------------------------------------------------
module tdsac_div
#(
    parameter int NUM_W   = 33,
    parameter int DIVISOR = 10000,
    localparam int QUO_W  = NUM_W + 1 - $clog2(DIVISOR)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    output logic             busy,
    output logic [QUO_W-1:0] quo
);

    // floor(num / DIVISOR) = (num * RECIP) >> RSHIFT for every num below 2^NUM_W
    localparam int RSHIFT                 = NUM_W + $clog2(DIVISOR);
    localparam longint unsigned RECIP     = ((64'd1 << RSHIFT) + DIVISOR - 1) / DIVISOR;
    localparam int RECIP_W                = NUM_W + 1;
    localparam int HALF_W                 = (RECIP_W + 1) / 2;
    localparam int RECIP_PAD_W            = 2 * HALF_W;
    localparam int PART_W                 = NUM_W + HALF_W;
    localparam int ACC_W                  = NUM_W + RECIP_PAD_W;
    localparam logic [RECIP_PAD_W-1:0] RECIP_V = RECIP_PAD_W'(RECIP);
    localparam logic [1:0] PASS_LOW       = 2'd2;
    localparam logic [1:0] PASS_HIGH      = 2'd1;

    logic [1:0]        cnt_reg;
    logic [NUM_W-1:0]  num_reg;
    logic [ACC_W-1:0]  acc_reg;
    logic [HALF_W-1:0] recip_part;
    logic [PART_W-1:0] part;

    assign busy       = cnt_reg != 2'd0;
    assign recip_part = (cnt_reg == PASS_LOW) ? RECIP_V[HALF_W-1:0]
                                              : RECIP_V[RECIP_PAD_W-1:HALF_W];
    assign part       = PART_W'(num_reg) * PART_W'(recip_part);
    assign quo        = acc_reg[RSHIFT +: QUO_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= PASS_LOW;
        end
        else if (busy)
        begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= num;
        end
        else if (cnt_reg == PASS_LOW)
        begin
            acc_reg <= ACC_W'(part);
        end
        else if (cnt_reg == PASS_HIGH)
        begin
            acc_reg <= acc_reg + (ACC_W'(part) << HALF_W);
        end
    end

endmodule

// ===== sv/tdsac_datapath.sv =====
// ----------------------------------------------------------------------------
// tdsac_datapath
// Accumulators, configuration registers, shared multiplier, divider,
// polynomial accumulator and result register.
// ----------------------------------------------------------------------------
module tdsac_datapath
    import tdsac_pkg::*;
#(
    parameter int INNER_SAMPLES = 10,
    parameter int OUTER_GROUPS  = 10,
    parameter int SAMPLE_BITS   = 12
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  dp_cmd_t               cmd,
    output dp_status_t            status,
    input  logic [SAMPLE_BITS-1:0] sample,
    input  logic                  read_failed,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic [PPM_W-1:0]      tds_ppm_sixteenths,
    output logic [MEAN_W-1:0]     mean_code_tenths,
    output logic [FAIL_W-1:0]     failed_groups
);

    // sum * vref * 2^16 / (groups * 2^bits * 1000) = sum * vref * 2^SHIFT / DIVISOR
    localparam int SHIFT   = VOLT_FRAC - SAMPLE_BITS;
    localparam int SV_W    = BSUM_W + VREF_W;
    localparam int NUM_W   = SV_W + SHIFT;
    localparam int DIVISOR = OUTER_GROUPS * MV_PER_V;
    localparam int VW      = NUM_W - $clog2(DIVISOR) + 1;
    localparam int V2W     = 2 * VW - VOLT_FRAC;
    localparam int V3W     = V2W + VW - VOLT_FRAC;
    localparam int MAW     = imax(imax(BSUM_W, VW), imax(V2W, COEF_LIN_W));
    localparam int MBW     = imax(imax(VREF_W, VW), imax(V3W, V2W));
    localparam int PW      = MAW + MBW;
    localparam int AW      = imax(imax(COEF_CUB_W + V3W, COEF_LIN_W + VW),
                                  imax(COEF_SQ_W + V2W, P_FRAC + MIN_PPM_W)) + 2;
    localparam int SAT_LSB = P_SHIFT + PPM_W;

    // group mean as a reciprocal product, exact over the whole group sum range
    localparam int GRP_SHIFT = GSUM_W + $clog2(INNER_SAMPLES);
    localparam longint unsigned GRP_RECIP =
        ((64'd1 << GRP_SHIFT) + INNER_SAMPLES - 1) / INNER_SAMPLES;
    localparam int GPROD_W   = 2 * GSUM_W + 1;

    logic [COEF_CUB_W-1:0] coef_cubic_reg;
    logic [COEF_SQ_W-1:0]  coef_square_reg;
    logic [COEF_LIN_W-1:0] coef_linear_reg;
    logic [VREF_W-1:0]     vref_mv_reg;
    logic [MIN_PPM_W-1:0]  min_ppm_reg;

    logic [GSUM_W-1:0]     group_sum_reg;
    logic [CNT_W-1:0]      group_count_reg;
    logic [BSUM_W-1:0]     batch_sum_reg;
    logic [CNT_W-1:0]      batch_count_reg;
    logic [CNT_W-1:0]      fail_count_reg;
    logic [GPROD_W-1:0]    group_prod;
    logic [BSUM_W-1:0]     group_mean;

    logic [MAW-1:0]        mul_a;
    logic [MBW-1:0]        mul_b;
    logic [PW-1:0]         mul_p;
    logic [PW-1:0]         prod_reg;
    logic [VW-1:0]         v_reg;
    logic [V2W-1:0]        v2_reg;
    logic [V3W-1:0]        v3_reg;
    logic [AW-1:0]         acc_reg;
    logic [AW-1:0]         acc_term;
    logic [AW-1:0]         thr;
    logic [PPM_W-1:0]      ppm_reg;
    logic [PPM_W-1:0]      ppm_next;
    logic                  below_min;
    logic                  saturate;

    logic [NUM_W-1:0]      div_num;
    logic [VW-1:0]         div_quo;
    logic                  div_busy;

    logic [PPM_W-1:0]      out_ppm_reg;
    logic [MEAN_W-1:0]     out_mean_reg;
    logic [FAIL_W-1:0]     out_fail_reg;

    // ---------------- configuration ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_cubic_reg  <= COEF_CUB_RST;
            coef_square_reg <= COEF_SQ_RST;
            coef_linear_reg <= COEF_LIN_RST;
            vref_mv_reg     <= VREF_RST;
            min_ppm_reg     <= MIN_PPM_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_COEF_CUBIC:  coef_cubic_reg  <= cfg_data[COEF_CUB_W-1:0];
                CFG_COEF_SQUARE: coef_square_reg <= cfg_data[COEF_SQ_W-1:0];
                CFG_COEF_LINEAR: coef_linear_reg <= cfg_data[COEF_LIN_W-1:0];
                CFG_VREF_MV:     vref_mv_reg     <= cfg_data[VREF_W-1:0];
                CFG_MIN_PPM:     min_ppm_reg     <= cfg_data[MIN_PPM_W-1:0];
                default:         ;
            endcase
        end
    end

    // ---------------- accumulation ----------------
    assign group_prod = GPROD_W'(group_sum_reg) * GPROD_W'(GRP_RECIP);
    assign group_mean = BSUM_W'(group_prod[GPROD_W-1:GRP_SHIFT]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_sum_reg   <= '0;
            group_count_reg <= '0;
            batch_sum_reg   <= '0;
            batch_count_reg <= '0;
            fail_count_reg  <= '0;
        end
        else if (cmd.take)
        begin
            if (read_failed)
            begin
                // discard the partial group, it ends with mean zero
                fail_count_reg  <= fail_count_reg + 1'b1;
                batch_count_reg <= batch_count_reg + 1'b1;
                group_sum_reg   <= '0;
                group_count_reg <= '0;
            end
            else
            begin
                group_sum_reg   <= group_sum_reg + GSUM_W'(sample);
                group_count_reg <= group_count_reg + 1'b1;
            end
        end
        else if (cmd.end_group)
        begin
            batch_sum_reg   <= batch_sum_reg + group_mean;
            batch_count_reg <= batch_count_reg + 1'b1;
            group_sum_reg   <= '0;
            group_count_reg <= '0;
        end
        else if (cmd.out_load)
        begin
            batch_sum_reg   <= '0;
            batch_count_reg <= '0;
            fail_count_reg  <= '0;
        end
    end

    assign status.group_full = group_count_reg >= CNT_W'(INNER_SAMPLES);
    assign status.batch_full = batch_count_reg >= CNT_W'(OUTER_GROUPS);
    assign status.div_busy   = div_busy;

    // ---------------- divider ----------------
    assign div_num = NUM_W'(prod_reg[SV_W-1:0]) << SHIFT;

    tdsac_div #(
        .NUM_W   (NUM_W),
        .DIVISOR (DIVISOR)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (div_num),
        .busy  (div_busy),
        .quo   (div_quo)
    );

    // ---------------- shared multiplier ----------------
    always_comb
    begin
        case (cmd.mul_sel)
            MUL_SUM_VREF:
            begin
                mul_a = MAW'(batch_sum_reg);
                mul_b = MBW'(vref_mv_reg);
            end
            MUL_V_V:
            begin
                mul_a = MAW'(v_reg);
                mul_b = MBW'(v_reg);
            end
            MUL_V2_V:
            begin
                mul_a = MAW'(v2_reg);
                mul_b = MBW'(v_reg);
            end
            MUL_C3_V3:
            begin
                mul_a = MAW'(coef_cubic_reg);
                mul_b = MBW'(v3_reg);
            end
            MUL_C1_V:
            begin
                mul_a = MAW'(coef_linear_reg);
                mul_b = MBW'(v_reg);
            end
            MUL_C2_V2:
            begin
                mul_a = MAW'(coef_square_reg);
                mul_b = MBW'(v2_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p    = PW'(mul_a) * PW'(mul_b);
    assign acc_term = AW'(prod_reg);

    // ---------------- result ----------------
    assign thr       = AW'({min_ppm_reg, {P_FRAC{1'b0}}});
    assign below_min = acc_reg[AW-1] || (acc_reg < thr);
    assign saturate  = |acc_reg[AW-1:SAT_LSB];

    always_comb
    begin
        if (below_min)
        begin
            ppm_next = '0;
        end
        else if (saturate)
        begin
            ppm_next = '1;
        end
        else
        begin
            ppm_next = acc_reg[P_SHIFT +: PPM_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
        begin
            prod_reg <= mul_p;
        end
        if (cmd.ld_v)
        begin
            v_reg <= div_quo;
        end
        if (cmd.ld_v2)
        begin
            v2_reg <= prod_reg[VOLT_FRAC +: V2W];
        end
        if (cmd.ld_v3)
        begin
            v3_reg <= prod_reg[VOLT_FRAC +: V3W];
        end
        case (cmd.acc_op)
            ACC_LOAD: acc_reg <= acc_term;
            ACC_ADD:  acc_reg <= acc_reg + acc_term;
            ACC_SUB:  acc_reg <= acc_reg - acc_term;
            default:  ;
        endcase
        if (cmd.ld_ppm)
        begin
            ppm_reg <= ppm_next;
        end
        if (cmd.out_load)
        begin
            out_ppm_reg  <= ppm_reg;
            out_mean_reg <= batch_sum_reg;
            out_fail_reg <= fail_count_reg;
        end
    end

    assign tds_ppm_sixteenths = out_ppm_reg;
    assign mean_code_tenths   = out_mean_reg;
    assign failed_groups      = out_fail_reg;

endmodule

// ===== sv/tdsac_ctrl.sv =====
// ----------------------------------------------------------------------------
// tdsac_ctrl
// Sequencer: takes one beat at a time, closes groups and runs the voltage
// division and polynomial steps at the end of a batch.
// ----------------------------------------------------------------------------
module tdsac_ctrl
    import tdsac_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    output logic       m_tvalid,
    input  logic       m_tready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_BDIV_START,
        ST_BDIV,
        ST_MUL_VV,
        ST_LD_V2,
        ST_MUL_V2V,
        ST_LD_V3,
        ST_ACC_LOAD,
        ST_ACC_ADD,
        ST_ACC_SUB,
        ST_PPM,
        ST_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   s_tready_reg;
    logic   m_tvalid_reg;
    logic   m_tvalid_next;

    always_comb
    begin
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        cmd           = '0;
        cmd.mul_sel   = MUL_SUM_VREF;
        cmd.acc_op    = ACC_HOLD;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid && s_tready_reg)
                begin
                    cmd.take   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (status.group_full)
                begin
                    // fold the group mean in, then look at the batch again
                    cmd.end_group = 1'b1;
                    state_next    = ST_CHECK;
                end
                else if (status.batch_full)
                begin
                    cmd.mul_en  = 1'b1;
                    cmd.mul_sel = MUL_SUM_VREF;
                    state_next  = ST_BDIV_START;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_BDIV_START:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_BDIV;
            end
            ST_BDIV:
            begin
                if (!status.div_busy)
                begin
                    cmd.ld_v   = 1'b1;
                    state_next = ST_MUL_VV;
                end
            end
            ST_MUL_VV:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_V_V;
                state_next  = ST_LD_V2;
            end
            ST_LD_V2:
            begin
                cmd.ld_v2  = 1'b1;
                state_next = ST_MUL_V2V;
            end
            ST_MUL_V2V:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_V2_V;
                state_next  = ST_LD_V3;
            end
            ST_LD_V3:
            begin
                // V3 leaves the product register as the linear term enters it
                cmd.ld_v3   = 1'b1;
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_C1_V;
                state_next  = ST_ACC_LOAD;
            end
            ST_ACC_LOAD:
            begin
                cmd.acc_op  = ACC_LOAD;
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_C3_V3;
                state_next  = ST_ACC_ADD;
            end
            ST_ACC_ADD:
            begin
                cmd.acc_op  = ACC_ADD;
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_C2_V2;
                state_next  = ST_ACC_SUB;
            end
            ST_ACC_SUB:
            begin
                cmd.acc_op = ACC_SUB;
                state_next = ST_PPM;
            end
            ST_PPM:
            begin
                cmd.ld_ppm = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                // hold until the result register is free or being drained
                if (!m_tvalid_reg || m_tready)
                begin
                    cmd.out_load  = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            s_tready_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            s_tready_reg <= (state_next == ST_IDLE);
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign s_tready = s_tready_reg;
    assign m_tvalid = m_tvalid_reg;

endmodule
